// File: rtl/core/pbwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbwf_pkg;

    // Longest message accepted; the byte counter must hold this value itself
    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int OFFSET_W          = 16;
    localparam int VALUE_W           = 64;
    localparam int NUMBER_W          = 32;
    localparam int KIND_W            = 3;
    localparam int VCOUNT_W          = 4;
    localparam int FCOUNT_W          = 3;

    // Index of the final byte of a varint (ten bytes at most)
    localparam logic [VCOUNT_W-1:0] VARINT_LAST_IDX = 4'd9;
    // Index of the final byte of fixed64 / fixed32 values
    localparam logic [FCOUNT_W-1:0] FIX64_LAST_IDX  = 3'd7;
    localparam logic [FCOUNT_W-1:0] FIX32_LAST_IDX  = 3'd3;

    // Wire type codes
    localparam logic [KIND_W-1:0] WK_VARINT  = 3'd0;
    localparam logic [KIND_W-1:0] WK_FIX64   = 3'd1;
    localparam logic [KIND_W-1:0] WK_LENGTH  = 3'd2;
    localparam logic [KIND_W-1:0] WK_FIX32   = 3'd5;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FIX32   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TRUNC   = 3'd1,
        ST_BADTYPE = 3'd2,
        ST_VARLONG = 3'd3,
        ST_TOOLONG = 3'd4
    } status_t;

    // One result as handed from the decoder to the output register
    typedef struct packed {
        logic                present;
        logic                field_valid;
        logic [NUMBER_W-1:0] field_number;
        logic [KIND_W-1:0]   wire_kind;
        logic [VALUE_W-1:0]  field_value;
        logic [OFFSET_W-1:0] payload_offset;
        logic                message_end;
        status_t             parse_status;
    } result_t;

    // Bit position of varint group c (seven bits per byte)
    function automatic logic [5:0] varint_shift(input logic [VCOUNT_W-1:0] c);
        logic [5:0] amt;
        amt = 6'(7 * c);
        return amt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pbwf_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pbwf_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_value,
    input  wire logic       last_byte,
    input  wire logic       take,
    output logic            full,
    output logic [7:0]      byte_q,
    output logic            last_q
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Accept a new request whenever the held byte is empty or leaves this cycle
    assign in_ready = !full_reg || take;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Hold the payload of the accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_value;
            last_reg <= last_byte;
        end
    end

    assign full   = full_reg;
    assign byte_q = byte_reg;
    assign last_q = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/pbwf_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module pbwf_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       byte_in,
    input  wire logic             last_in,
    output pbwf_pkg::result_t     result
);

    pbwf_pkg::phase_t                        phase_reg, phase_next;
    logic [pbwf_pkg::VALUE_W-1:0]            accum_reg, accum_next;
    logic [pbwf_pkg::VCOUNT_W-1:0]           vcount_reg, vcount_next;
    logic [pbwf_pkg::NUMBER_W-1:0]           number_reg, number_next;
    logic [pbwf_pkg::KIND_W-1:0]             kind_reg, kind_next;
    logic [pbwf_pkg::FCOUNT_W-1:0]           fcount_reg, fcount_next;
    logic [pbwf_pkg::VALUE_W-1:0]            remain_reg, remain_next;
    logic [pbwf_pkg::POS_W-1:0]              pos_reg, pos_next;
    pbwf_pkg::status_t                       err_reg, err_next;

    logic [pbwf_pkg::VCOUNT_W-1:0]           vidx;
    logic [pbwf_pkg::VALUE_W-1:0]            vmerged;
    logic                                    vlong;
    logic [pbwf_pkg::VALUE_W-1:0]            fmerged;
    logic                                    fdone;
    logic [pbwf_pkg::VALUE_W-1:0]            remain_dec;
    logic [pbwf_pkg::OFFSET_W-1:0]           pos_plus1;
    logic                                    emit;
    logic [pbwf_pkg::VALUE_W-1:0]            emit_value;
    logic [pbwf_pkg::OFFSET_W-1:0]           emit_offset;
    pbwf_pkg::status_t                       status;

    // Varint byte merge: seven bits per byte, a tenth byte only lands bit 63
    assign vidx    = (vcount_reg > pbwf_pkg::VARINT_LAST_IDX) ? pbwf_pkg::VARINT_LAST_IDX
                                                              : vcount_reg;
    assign vmerged = accum_reg
                   | ({57'd0, byte_in[6:0]} << pbwf_pkg::varint_shift(vidx));
    assign vlong   = byte_in[7] && (vidx >= pbwf_pkg::VARINT_LAST_IDX);

    // Little-endian fixed byte merge
    assign fmerged = accum_reg | ({56'd0, byte_in} << {fcount_reg, 3'b000});
    assign fdone   = (phase_reg == pbwf_pkg::PH_FIX64)
                   ? (fcount_reg == pbwf_pkg::FIX64_LAST_IDX)
                   : (fcount_reg >= pbwf_pkg::FIX32_LAST_IDX);

    assign remain_dec = remain_reg - 64'd1;
    assign pos_plus1  = pos_reg[pbwf_pkg::OFFSET_W-1:0] + 16'd1;

    // Next state and result for one byte
    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        vcount_next = vcount_reg;
        number_next = number_reg;
        kind_next   = kind_reg;
        fcount_next = fcount_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        err_next    = err_reg;
        emit        = 1'b0;
        emit_value  = '0;
        emit_offset = '0;
        status      = pbwf_pkg::ST_OK;

        if (err_reg == pbwf_pkg::ST_OK)
        begin
            if (pos_reg >= pbwf_pkg::POS_W'(pbwf_pkg::MAX_MESSAGE_BYTES))
            begin
                err_next = pbwf_pkg::ST_TOOLONG;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                case (phase_reg)
                    pbwf_pkg::PH_TAG:
                    begin
                        accum_next = vmerged;
                        if (!byte_in[7])
                        begin
                            number_next = vmerged[pbwf_pkg::NUMBER_W+2:3];
                            kind_next   = vmerged[2:0];
                            accum_next  = '0;
                            vcount_next = '0;
                            fcount_next = '0;
                            case (vmerged[2:0])
                                pbwf_pkg::WK_VARINT: phase_next = pbwf_pkg::PH_VARINT;
                                pbwf_pkg::WK_FIX64:  phase_next = pbwf_pkg::PH_FIX64;
                                pbwf_pkg::WK_LENGTH: phase_next = pbwf_pkg::PH_LENGTH;
                                pbwf_pkg::WK_FIX32:  phase_next = pbwf_pkg::PH_FIX32;
                                default:             err_next   = pbwf_pkg::ST_BADTYPE;
                            endcase
                        end
                        else if (vlong)
                        begin
                            err_next = pbwf_pkg::ST_VARLONG;
                        end
                        else
                        begin
                            vcount_next = vidx + 1'b1;
                        end
                    end
                    pbwf_pkg::PH_VARINT:
                    begin
                        accum_next = vmerged;
                        if (!byte_in[7])
                        begin
                            emit       = 1'b1;
                            emit_value = vmerged;
                        end
                        else if (vlong)
                        begin
                            err_next = pbwf_pkg::ST_VARLONG;
                        end
                        else
                        begin
                            vcount_next = vidx + 1'b1;
                        end
                    end
                    pbwf_pkg::PH_LENGTH:
                    begin
                        accum_next = vmerged;
                        if (!byte_in[7])
                        begin
                            if (vmerged == '0)
                            begin
                                emit        = 1'b1;
                                emit_offset = pos_plus1;
                            end
                            else
                            begin
                                remain_next = vmerged;
                                phase_next  = pbwf_pkg::PH_PAYLOAD;
                            end
                        end
                        else if (vlong)
                        begin
                            err_next = pbwf_pkg::ST_VARLONG;
                        end
                        else
                        begin
                            vcount_next = vidx + 1'b1;
                        end
                    end
                    pbwf_pkg::PH_PAYLOAD:
                    begin
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            emit        = 1'b1;
                            emit_value  = accum_reg;
                            emit_offset = pos_plus1 - accum_reg[pbwf_pkg::OFFSET_W-1:0];
                        end
                    end
                    pbwf_pkg::PH_FIX64,
                    pbwf_pkg::PH_FIX32:
                    begin
                        accum_next = fmerged;
                        if (fdone)
                        begin
                            emit       = 1'b1;
                            emit_value = fmerged;
                        end
                        else
                        begin
                            fcount_next = fcount_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = pbwf_pkg::PH_TAG;
                    end
                endcase

                // Drop back to tag parsing after a completed field
                if (emit)
                begin
                    phase_next  = pbwf_pkg::PH_TAG;
                    accum_next  = '0;
                    vcount_next = '0;
                    fcount_next = '0;
                    remain_next = '0;
                end
            end
        end

        // Closing status on the last byte
        if (last_in)
        begin
            if (err_next != pbwf_pkg::ST_OK)
            begin
                status = err_next;
            end
            else if (phase_next != pbwf_pkg::PH_TAG || vcount_next != '0)
            begin
                status = pbwf_pkg::ST_TRUNC;
            end
        end

        result.present        = emit || last_in;
        result.field_valid    = emit;
        result.field_number   = emit ? number_next : '0;
        result.wire_kind      = emit ? kind_next : '0;
        result.field_value    = emit_value;
        result.payload_offset = (emit && kind_next == pbwf_pkg::WK_LENGTH) ? emit_offset : '0;
        result.message_end    = last_in;
        result.parse_status   = status;
    end

    // Advance parser state; clear everything at the end of a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pbwf_pkg::PH_TAG;
            accum_reg  <= '0;
            vcount_reg <= '0;
            number_reg <= '0;
            kind_reg   <= '0;
            fcount_reg <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            err_reg    <= pbwf_pkg::ST_OK;
        end
        else if (step)
        begin
            if (last_in)
            begin
                phase_reg  <= pbwf_pkg::PH_TAG;
                accum_reg  <= '0;
                vcount_reg <= '0;
                number_reg <= '0;
                kind_reg   <= '0;
                fcount_reg <= '0;
                remain_reg <= '0;
                pos_reg    <= '0;
                err_reg    <= pbwf_pkg::ST_OK;
            end
            else
            begin
                phase_reg  <= phase_next;
                accum_reg  <= accum_next;
                vcount_reg <= vcount_next;
                number_reg <= number_next;
                kind_reg   <= kind_next;
                fcount_reg <= fcount_next;
                remain_reg <= remain_next;
                pos_reg    <= pos_next;
                err_reg    <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pbwf_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pbwf_out_stage (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire pbwf_pkg::result_t        result,
    output logic                          busy,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          field_valid,
    output logic [pbwf_pkg::NUMBER_W-1:0] field_number,
    output logic [pbwf_pkg::KIND_W-1:0]   wire_kind,
    output logic [pbwf_pkg::VALUE_W-1:0]  field_value,
    output logic [pbwf_pkg::OFFSET_W-1:0] payload_offset,
    output logic                          message_end,
    output logic [2:0]                    parse_status
);

    logic              valid_reg;
    logic              valid_next;
    pbwf_pkg::result_t data_reg;

    // Register is blocked only while a result waits and the sink stalls
    assign busy = valid_reg && !out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid      = valid_reg;
    assign field_valid    = data_reg.field_valid;
    assign field_number   = data_reg.field_number;
    assign wire_kind      = data_reg.wire_kind;
    assign field_value    = data_reg.field_value;
    assign payload_offset = data_reg.payload_offset;
    assign message_end    = data_reg.message_end;
    assign parse_status   = data_reg.parse_status;

endmodule

`default_nettype wire

// File: rtl/core/protobuf_wire_field_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming protocol buffers wire-format field parser. Feed one message byte per
// request with last_byte set on the final byte; the unit takes one byte every clock
// cycle unless a result is stalled; a byte is held in the input register, decoded
// in a single pass through the tag, varint, fixed or length logic into the output
// register. A result is produced for each completed field (length-delimited fields
// report payload offset and length once the payload has been skipped) and always on
// the last byte, which carries message_end and the message status. After the first
// error no fields are reported until the last byte. Back-pressure on the result
// side stalls the input only while a result is waiting in the output register.
module protobuf_wire_field_parser_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               byte_value,
    input  wire logic                     last_byte,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          field_valid,
    output logic [pbwf_pkg::NUMBER_W-1:0] field_number,
    output logic [pbwf_pkg::KIND_W-1:0]   wire_kind,
    output logic [pbwf_pkg::VALUE_W-1:0]  field_value,
    output logic [pbwf_pkg::OFFSET_W-1:0] payload_offset,
    output logic                          message_end,
    output logic [2:0]                    parse_status
);

    logic              held;
    logic [7:0]        held_byte;
    logic              held_last;
    logic              out_busy;
    logic              step;
    pbwf_pkg::result_t result;

    // Decode the held byte when the output register can take its result
    assign step = held && !out_busy;

    pbwf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .take       (step),
        .full       (held),
        .byte_q     (held_byte),
        .last_q     (held_last)
    );

    pbwf_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (held_byte),
        .last_in (held_last),
        .result  (result)
    );

    pbwf_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (step && result.present),
        .result         (result),
        .busy           (out_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .field_valid    (field_valid),
        .field_number   (field_number),
        .wire_kind      (wire_kind),
        .field_value    (field_value),
        .payload_offset (payload_offset),
        .message_end    (message_end),
        .parse_status   (parse_status)
    );

endmodule

`default_nettype wire

// File: tb/sv/protobuf_wire_field_parser_unit_test.sv
`timescale 1ns / 1ps

module protobuf_wire_field_parser_unit_test;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 1000;

    // One result as the parser should report it
    typedef struct {
        logic              field_valid;
        logic [31:0]       field_number;
        logic [2:0]        wire_kind;
        logic [63:0]       field_value;
        logic [15:0]       payload_offset;
        logic              message_end;
        pbwf_pkg::status_t parse_status;
    } field_report_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    logic [7:0]     byte_value;
    logic           last_byte;
    logic           out_valid;
    logic           out_ready;
    logic           field_valid;
    logic [31:0]    field_number;
    logic [2:0]     wire_kind;
    logic [63:0]    field_value;
    logic [15:0]    payload_offset;
    logic           message_end;
    logic [2:0]     parse_status;

    // Decoder state mirrored on the testbench side
    pbwf_pkg::phase_t  dec_phase;
    logic [63:0]       dec_accum;
    logic [3:0]        dec_vcount;
    logic [31:0]       dec_field_no;
    logic [2:0]        dec_kind;
    logic [2:0]        dec_fcount;
    logic [63:0]       dec_remaining;
    int unsigned       dec_pos;
    pbwf_pkg::status_t dec_fault;
    bit                emit_now;
    logic [63:0]       emit_value;
    logic [63:0]       emit_offset;

    field_report_t  pending_reports[$];
    logic [7:0]     msg_bytes[$];

    int             failures;
    int             bytes_sent;
    int             messages_sent;
    int             results_checked;
    int             fields_checked;
    int             closings_by_status[0:4];
    longint         cycle_count;
    bit             sender_idles;
    bit             sink_idles;
    bit             hold_requested;

    protobuf_wire_field_parser_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .field_valid    (field_valid),
        .field_number   (field_number),
        .wire_kind      (wire_kind),
        .field_value    (field_value),
        .payload_offset (payload_offset),
        .message_end    (message_end),
        .parse_status   (parse_status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    task automatic clear_decoder();
        dec_phase     = pbwf_pkg::PH_TAG;
        dec_accum     = '0;
        dec_vcount    = '0;
        dec_field_no  = '0;
        dec_kind      = '0;
        dec_fcount    = '0;
        dec_remaining = '0;
        dec_pos       = 0;
        dec_fault     = pbwf_pkg::ST_OK;
    endtask

    task automatic finish_field(input logic [63:0] value, input logic [63:0] offset);
        emit_now      = 1'b1;
        emit_value    = value;
        emit_offset   = offset;
        dec_phase     = pbwf_pkg::PH_TAG;
        dec_accum     = '0;
        dec_vcount    = '0;
        dec_fcount    = '0;
        dec_remaining = '0;
    endtask

    // Merge one seven-bit group: 1 done, 0 more to come, -1 over ten bytes
    function automatic int take_varint_group(input logic [7:0] b);
        logic [3:0] c;
        c = (dec_vcount > pbwf_pkg::VARINT_LAST_IDX) ? pbwf_pkg::VARINT_LAST_IDX
                                                     : dec_vcount;
        dec_accum = dec_accum | ({57'd0, b[6:0]} << (7 * c));
        if (!b[7])
            return 1;
        if (c >= pbwf_pkg::VARINT_LAST_IDX)
            return -1;
        dec_vcount = c + 4'd1;
        return 0;
    endfunction

    task automatic decode_step(input logic [7:0] b, input int unsigned pos);
        int         r;
        logic [2:0] last_idx;
        case (dec_phase)
            pbwf_pkg::PH_TAG:
            begin
                r = take_varint_group(b);
                if (r < 0)
                    dec_fault = pbwf_pkg::ST_VARLONG;
                else if (r > 0)
                begin
                    dec_kind     = dec_accum[2:0];
                    dec_field_no = dec_accum[34:3];
                    dec_accum    = '0;
                    dec_vcount   = '0;
                    dec_fcount   = '0;
                    case (dec_kind)
                        pbwf_pkg::WK_VARINT: dec_phase = pbwf_pkg::PH_VARINT;
                        pbwf_pkg::WK_FIX64:  dec_phase = pbwf_pkg::PH_FIX64;
                        pbwf_pkg::WK_LENGTH: dec_phase = pbwf_pkg::PH_LENGTH;
                        pbwf_pkg::WK_FIX32:  dec_phase = pbwf_pkg::PH_FIX32;
                        default:             dec_fault = pbwf_pkg::ST_BADTYPE;
                    endcase
                end
            end
            pbwf_pkg::PH_VARINT:
            begin
                r = take_varint_group(b);
                if (r < 0)
                    dec_fault = pbwf_pkg::ST_VARLONG;
                else if (r > 0)
                    finish_field(dec_accum, '0);
            end
            pbwf_pkg::PH_LENGTH:
            begin
                r = take_varint_group(b);
                if (r < 0)
                    dec_fault = pbwf_pkg::ST_VARLONG;
                else if (r > 0)
                begin
                    if (dec_accum == '0)
                        finish_field('0, 64'(pos) + 64'd1);
                    else
                    begin
                        dec_remaining = dec_accum;
                        dec_phase     = pbwf_pkg::PH_PAYLOAD;
                    end
                end
            end
            pbwf_pkg::PH_PAYLOAD:
            begin
                dec_remaining = dec_remaining - 64'd1;
                if (dec_remaining == '0)
                    finish_field(dec_accum, 64'(pos) + 64'd1 - dec_accum);
            end
            pbwf_pkg::PH_FIX64, pbwf_pkg::PH_FIX32:
            begin
                last_idx  = (dec_phase == pbwf_pkg::PH_FIX64) ? pbwf_pkg::FIX64_LAST_IDX
                                                              : pbwf_pkg::FIX32_LAST_IDX;
                dec_accum = dec_accum | ({56'd0, b} << (8 * dec_fcount));
                if (dec_fcount >= last_idx)
                    finish_field(dec_accum, '0);
                else
                    dec_fcount = dec_fcount + 3'd1;
            end
            default:
                dec_phase = pbwf_pkg::PH_TAG;
        endcase
    endtask

    // Advance the model by one accepted byte and queue any result it owes
    task automatic decode_wire_byte(input logic [7:0] b, input logic last);
        field_report_t     rep;
        pbwf_pkg::status_t st;
        emit_now    = 1'b0;
        emit_value  = '0;
        emit_offset = '0;
        st          = pbwf_pkg::ST_OK;
        if (dec_fault == pbwf_pkg::ST_OK)
        begin
            if (dec_pos >= pbwf_pkg::MAX_MESSAGE_BYTES)
                dec_fault = pbwf_pkg::ST_TOOLONG;
            else
            begin
                dec_pos++;
                decode_step(b, dec_pos - 1);
            end
        end
        if (dec_fault != pbwf_pkg::ST_OK)
            emit_now = 1'b0;
        if (emit_now || last)
        begin
            if (last)
            begin
                if (dec_fault != pbwf_pkg::ST_OK)
                    st = dec_fault;
                else if (dec_phase != pbwf_pkg::PH_TAG || dec_vcount != '0)
                    st = pbwf_pkg::ST_TRUNC;
                closings_by_status[int'(st)]++;
            end
            rep.field_valid    = emit_now;
            rep.field_number   = emit_now ? dec_field_no : '0;
            rep.wire_kind      = emit_now ? dec_kind : '0;
            rep.field_value    = emit_now ? emit_value : '0;
            rep.payload_offset = (emit_now && dec_kind == pbwf_pkg::WK_LENGTH)
                               ? emit_offset[15:0] : '0;
            rep.message_end    = last;
            rep.parse_status   = st;
            pending_reports.insert(pending_reports.size(), rep);
        end
        if (last)
            clear_decoder();
    endtask

    // Predict from every accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            decode_wire_byte(byte_value, last_byte);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_port(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        field_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, actual field_valid=%0d",
                         $time, field_valid);
                $display("    number=%0h kind=%0d value=%0h offset=%0h end=%0d status=%0d",
                         field_number, wire_kind, field_value, payload_offset,
                         message_end, parse_status);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_port("field_valid", want.field_valid, field_valid);
                check_port("field_number", want.field_number, field_number);
                check_port("wire_kind", want.wire_kind, wire_kind);
                check_port("field_value", want.field_value, field_value);
                check_port("payload_offset", want.payload_offset, payload_offset);
                check_port("message_end", want.message_end, message_end);
                check_port("parse_status", want.parse_status, parse_status);
                results_checked++;
                if (want.field_valid)
                    fields_checked++;
            end
        end
    end

    // Drive ready: random idling, or a long hold when asked for
    initial
    begin
        int held;
        held      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                held           = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                held--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !(sink_idles && $urandom_range(0, 99) < 15);
        end
    end

    // ------------------------------------------------------------------
    // Message building
    // ------------------------------------------------------------------

    function automatic int min_varint_len(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != '0)
            n++;
        return n;
    endfunction

    // Mostly minimal encodings, now and then padded with empty groups
    function automatic int padded_len(input logic [63:0] v);
        int n;
        n = min_varint_len(v);
        if ($urandom_range(0, 9) == 0)
            n = n + $urandom_range(0, 10 - n);
        return n;
    endfunction

    // Append one byte to the message under construction
    function automatic void add_msg_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void push_varint(input logic [63:0] v, input int n);
        int         i;
        logic [5:0] junk;
        for (i = 0; i < n; i++)
        begin
            if (i == 9)
            begin
                // Only bit 0 of a tenth group counts; fill the rest with noise
                junk = 6'($urandom_range(0, 63));
                add_msg_byte({1'b0, junk, v[63]});
            end
            else
                add_msg_byte({i < n - 1, v[7 * i +: 7]});
        end
    endfunction

    function automatic void push_tag(input logic [63:0] fnum, input logic [2:0] kind);
        logic [63:0] tag;
        tag = (fnum << 3) | {61'd0, kind};
        push_varint(tag, padded_len(tag));
    endfunction

    function automatic void push_random_bytes(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_msg_byte(8'($urandom));
    endfunction

    function automatic void push_overlong_varint();
        int i;
        for (i = 0; i < 10; i++)
            add_msg_byte(8'h80 | 8'($urandom_range(0, 127)));
    endfunction

    function automatic logic [63:0] random_field_number();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 64'($urandom_range(0, 31));
        else if (r < 9)
            return 64'($urandom);
        return {$urandom, $urandom} >> 3;
    endfunction

    function automatic void push_random_field();
        logic [63:0] v;
        int          len;
        case ($urandom_range(0, 3))
            0:
            begin
                push_tag(random_field_number(), pbwf_pkg::WK_VARINT);
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
                push_varint(v, padded_len(v));
            end
            1:
            begin
                push_tag(random_field_number(), pbwf_pkg::WK_FIX64);
                push_random_bytes(8);
            end
            2:
            begin
                push_tag(random_field_number(), pbwf_pkg::WK_LENGTH);
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(128, 300);
                else if ($urandom_range(0, 3) == 0)
                    len = 0;
                else
                    len = $urandom_range(1, 10);
                push_varint(64'(len), padded_len(64'(len)));
                push_random_bytes(len);
            end
            default:
            begin
                push_tag(random_field_number(), pbwf_pkg::WK_FIX32);
                push_random_bytes(4);
            end
        endcase
    endfunction

    // Well-formed fields, sometimes spoiled by a bad tag, a runaway varint,
    // an early end or plain noise
    function automatic void build_random_message();
        int          k;
        int          flaw;
        logic [2:0]  bad_kinds[4];
        bad_kinds = '{3'd3, 3'd4, 3'd6, 3'd7};
        msg_bytes.delete();
        for (k = $urandom_range(1, 5); k > 0; k--)
            push_random_field();
        flaw = $urandom_range(0, 99);
        if (flaw < 4)
        begin
            push_tag(random_field_number(), bad_kinds[$urandom_range(0, 3)]);
            push_random_bytes($urandom_range(0, 3));
        end
        else if (flaw < 8)
        begin
            case ($urandom_range(0, 2))
                0: ;
                1: push_tag(random_field_number(), pbwf_pkg::WK_VARINT);
                default: push_tag(random_field_number(), pbwf_pkg::WK_LENGTH);
            endcase
            push_overlong_varint();
            push_random_bytes($urandom_range(0, 2));
        end
        else if (flaw < 12)
        begin
            if (msg_bytes.size() > 1)
                repeat ($urandom_range(1, msg_bytes.size() - 1))
                    void'(msg_bytes.pop_back());
        end
        else if (flaw < 15)
        begin
            msg_bytes.delete();
            push_random_bytes($urandom_range(1, 12));
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (sender_idles)
        begin
            while ($urandom_range(0, 99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        last_byte  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_message();
        int i;
        messages_sent++;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One field of each wire type
    task automatic test_basic_fields();
        msg_bytes = '{8'h08, 8'h96, 8'h01};
        send_message();
        msg_bytes = '{8'h0D, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_message();
        msg_bytes = '{8'h1A, 8'h02, 8'hAA, 8'h55};
        send_message();
        msg_bytes = '{8'h09, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hFE};
        send_message();
    endtask

    // Empty payload, bad wire types and a message cut inside a field
    task automatic test_error_cases();
        msg_bytes = '{8'h12, 8'h00, 8'h0B, 8'h55};
        send_message();
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'h0F};
        send_message();
    endtask

    // Hold the result side so the parser fills up and stalls its input
    task automatic test_backpressure_fill();
        int m;
        int f;
        hold_requested = 1'b1;
        for (m = 0; m < 4; m++)
        begin
            msg_bytes.delete();
            for (f = 1; f <= 3; f++)
            begin
                push_tag(64'(f), pbwf_pkg::WK_VARINT);
                push_varint(64'($urandom_range(128, 16383)), 2);
            end
            send_message();
        end
    endtask

    task automatic test_random_messages(input int byte_budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            build_random_message();
            send_message();
        end
    endtask

    // Random traffic with both sides always willing
    task automatic test_no_idle_stretch();
        sender_idles = 1'b0;
        sink_idles   = 1'b0;
        test_random_messages(300);
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_value     = '0;
        last_byte      = 1'b0;
        sender_idles   = 1'b1;
        sink_idles     = 1'b1;
        hold_requested = 1'b0;
        clear_decoder();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_fields();
        test_error_cases();
        test_backpressure_fill();
        test_random_messages(RANDOM_BYTES);
        test_no_idle_stretch();
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d results, %0d carrying fields.",
                 bytes_sent, messages_sent, results_checked, fields_checked);
        $display("Closing status: ok %0d, truncated %0d, bad type %0d, long varint %0d, %s %0d",
                 closings_by_status[int'(pbwf_pkg::ST_OK)],
                 closings_by_status[int'(pbwf_pkg::ST_TRUNC)],
                 closings_by_status[int'(pbwf_pkg::ST_BADTYPE)],
                 closings_by_status[int'(pbwf_pkg::ST_VARLONG)],
                 "oversize", closings_by_status[int'(pbwf_pkg::ST_TOOLONG)]);
        if (failures == 0 && pending_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: protobuf_wire_field_parser_unit.f
rtl/core/pbwf_pkg.sv
rtl/core/pbwf_in_stage.sv
rtl/core/pbwf_decode.sv
rtl/core/pbwf_out_stage.sv
rtl/core/protobuf_wire_field_parser_unit.sv
tb/sv/protobuf_wire_field_parser_unit_test.sv
